// ===== hw/rtl/sse_pkg.sv =====
// ---------------------------------------------------------------------------
// Stride speed estimator package
// Control word layout, datapath operations, jump conditions and the
// microcode program shared by the sequencer and the datapath.
// ---------------------------------------------------------------------------
package sse_pkg;

   // Field widths
   localparam int STEP_W   = 4;
   localparam int CNT_W    = 5;
   localparam int IDX_W    = 2;
   localparam int CSR_W    = 16;

   // Arithmetic constants
   localparam logic [19:0] US_PER_S    = 20'd1000000;
   localparam logic [8:0]  Q8_ONE      = 9'd256;
   localparam logic [15:0] SPEED_LIMIT = 16'hFFFF;

   // Reset values of the configuration registers
   localparam logic [11:0] STRIDE_RESET = 12'd700;
   localparam logic [8:0]  WEIGHT_RESET = 9'd64;
   localparam logic [15:0] MAX_RESET    = 16'd5000;

   // Configuration register indexes
   localparam logic [IDX_W-1:0] CSR_STRIDE = 2'd0;
   localparam logic [IDX_W-1:0] CSR_WEIGHT = 2'd1;
   localparam logic [IDX_W-1:0] CSR_MAX    = 2'd2;

   // Program addresses
   localparam logic [STEP_W-1:0] S_ACCEPT  = 4'd0;
   localparam logic [STEP_W-1:0] S_NUM     = 4'd1;
   localparam logic [STEP_W-1:0] S_RANGE   = 4'd2;
   localparam logic [STEP_W-1:0] S_DIV1    = 4'd3;
   localparam logic [STEP_W-1:0] S_LOAD2   = 4'd4;
   localparam logic [STEP_W-1:0] S_DIV2    = 4'd5;
   localparam logic [STEP_W-1:0] S_INST_Q  = 4'd6;
   localparam logic [STEP_W-1:0] S_IZERO   = 4'd7;
   localparam logic [STEP_W-1:0] S_IMAX    = 4'd8;
   localparam logic [STEP_W-1:0] S_BLEND   = 4'd9;
   localparam logic [STEP_W-1:0] S_WAIT_UP = 4'd10;
   localparam logic [STEP_W-1:0] S_COMMIT  = 4'd11;
   localparam logic [STEP_W-1:0] S_WAIT_SK = 4'd12;
   localparam logic [STEP_W-1:0] S_SKIP    = 4'd13;

   typedef enum logic [3:0] {
      OP_NOP       = 4'd0,
      OP_LOAD      = 4'd1,
      OP_NUM       = 4'd2,
      OP_DIV       = 4'd3,
      OP_LOAD2     = 4'd4,
      OP_INST_Q    = 4'd5,
      OP_INST_ZERO = 4'd6,
      OP_INST_MAX  = 4'd7,
      OP_MIX       = 4'd8,
      OP_COMMIT    = 4'd9,
      OP_SKIP      = 4'd10
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER    = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_NO_REQ   = 3'd2,
      COND_NO_STEP  = 3'd3,
      COND_BIG      = 3'd4,
      COND_DIV_BUSY = 3'd5,
      COND_Q_ZERO   = 3'd6,
      COND_OUT_BUSY = 3'd7
   } cond_type;

   typedef struct packed {
      logic              accept_en;
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   // Datapath status seen by the jump logic
   typedef struct packed {
      logic req_valid;
      logic no_step;
      logic big;
      logic div_busy;
      logic q_zero;
      logic out_busy;
   } sse_flags_type;

   // Microcode program: one control word per step
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] pc);
      ucode_type uc;
      uc = '{accept_en: 1'b0, op: OP_NOP, cond: COND_NEVER, target: S_ACCEPT};
      case (pc)
         S_ACCEPT: begin
            uc.accept_en = 1'b1;
            uc.op        = OP_LOAD;
            uc.cond      = COND_NO_REQ;
            uc.target    = S_ACCEPT;
         end
         S_NUM: begin
            uc.op     = OP_NUM;
            uc.cond   = COND_NO_STEP;
            uc.target = S_WAIT_SK;
         end
         S_RANGE: begin
            uc.cond   = COND_BIG;
            uc.target = S_IZERO;
         end
         S_DIV1: begin
            uc.op     = OP_DIV;
            uc.cond   = COND_DIV_BUSY;
            uc.target = S_DIV1;
         end
         S_LOAD2: begin
            uc.op     = OP_LOAD2;
            uc.cond   = COND_Q_ZERO;
            uc.target = S_IMAX;
         end
         S_DIV2: begin
            uc.op     = OP_DIV;
            uc.cond   = COND_DIV_BUSY;
            uc.target = S_DIV2;
         end
         S_INST_Q: begin
            uc.op     = OP_INST_Q;
            uc.cond   = COND_ALWAYS;
            uc.target = S_BLEND;
         end
         S_IZERO: begin
            uc.op     = OP_INST_ZERO;
            uc.cond   = COND_ALWAYS;
            uc.target = S_BLEND;
         end
         S_IMAX: begin
            uc.op = OP_INST_MAX;
         end
         S_BLEND: begin
            uc.op = OP_MIX;
         end
         S_WAIT_UP: begin
            uc.cond   = COND_OUT_BUSY;
            uc.target = S_WAIT_UP;
         end
         S_COMMIT: begin
            uc.op     = OP_COMMIT;
            uc.cond   = COND_ALWAYS;
            uc.target = S_ACCEPT;
         end
         S_WAIT_SK: begin
            uc.cond   = COND_OUT_BUSY;
            uc.target = S_WAIT_SK;
         end
         S_SKIP: begin
            uc.op     = OP_SKIP;
            uc.cond   = COND_ALWAYS;
            uc.target = S_ACCEPT;
         end
         default: begin
            uc.cond   = COND_ALWAYS;
            uc.target = S_ACCEPT;
         end
      endcase
      return uc;
   endfunction

endpackage

// ===== hw/rtl/sse_seq.sv =====
// ---------------------------------------------------------------------------
// Stride speed estimator sequencer
// Step counter over the microcode table with conditional jumps; presents
// the current control word to the datapath.
// ---------------------------------------------------------------------------
module sse_seq
   import sse_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  sse_flags_type flags,
   output ucode_type     ctl
);

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   logic              take;

   // Fetch the control word
   assign ctl = ucode_rom(pc_ff);

   // Evaluate the jump condition
   always_comb begin
      unique case (ctl.cond)
         COND_NEVER:    take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_NO_REQ:   take = !flags.req_valid;
         COND_NO_STEP:  take = flags.no_step;
         COND_BIG:      take = flags.big;
         COND_DIV_BUSY: take = flags.div_busy;
         COND_Q_ZERO:   take = flags.q_zero;
         COND_OUT_BUSY: take = flags.out_busy;
         default:       take = 1'b1;
      endcase
   end

   // Jump or advance
   assign pc_in = take ? ctl.target : pc_ff + STEP_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_ACCEPT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== hw/rtl/stride_speed_estimator.sv =====
// ---------------------------------------------------------------------------
// Stride speed estimator
// Turns step reports (cumulative step count, microsecond timestamp) into a
// smoothed, capped walking speed in mm/s.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one step report per item; rsp_* returns one result per
//   item: the speed and a status bit (1 when the step count did not move and
//   the item was ignored). csr_* writes stride length, smoothing weight and
//   speed cap; write only while the block is idle.
//   An updating item runs through the second division only when the
//   interval needs it, and takes fewer steps when the interval is zero or
//   too large for it; each division makes one quotient bit per cycle
//   through the shared restoring divider. One item is in work at a time,
//   so the block takes no new item before it is through with the last;
//   req_stall is low only while the sequencer waits at its entry step and
//   reset is low.
//   The result sits in an output register; the block accepts the next item
//   while it waits, and stalls only before writing a new result over it.
//   Reset (synchronous) clears the step history and smoothed speed to zero,
//   loads the default configuration and drops any pending result.
// ---------------------------------------------------------------------------
module stride_speed_estimator
   import sse_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [31:0]      req_step_total,
   input  logic [63:0]      req_time_us,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [15:0]      rsp_speed_mm_s,
   output logic             rsp_status,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   ucode_type     ctl;
   sse_flags_type flags;

   // Configuration
   logic [11:0] stride_ff, stride_in;
   logic [8:0]  weight_ff, weight_in;
   logic [15:0] max_ff,    max_in;

   // History
   logic [31:0] last_step_ff, last_step_in;
   logic [63:0] last_time_ff, last_time_in;
   logic [15:0] smooth_ff,    smooth_in;

   // Working registers
   logic [31:0]      cur_step_ff, cur_step_in;
   logic [63:0]      cur_time_ff, cur_time_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      quo_ff, quo_in;
   logic [31:0]      dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      num_ff, num_in;
   logic [15:0]      inst_ff, inst_in;
   logic [16:0]      mix_ff, mix_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_speed_ff, rsp_speed_in;
   logic        rsp_status_ff, rsp_status_in;

   // Combinational helpers
   logic        accept;
   logic [63:0] dtime;
   logic [31:0] dsteps;
   logic [32:0] div_part;
   logic [32:0] div_diff;
   logic        div_ge;
   logic [31:0] num_mul;
   logic [8:0]  w_sat;
   logic [8:0]  w_inv;
   logic [24:0] mix_old;
   logic [24:0] mix_new;
   logic [24:0] mix_sum;
   logic [15:0] capped;

   sse_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   // Handshake
   assign req_stall      = reset || !ctl.accept_en;
   assign accept         = req_valid && !req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_speed_mm_s = rsp_speed_ff;
   assign rsp_status     = rsp_status_ff;

   // Status for the jump logic
   assign flags.req_valid = req_valid;
   assign flags.no_step   = (dvs_ff == 32'd0);
   assign flags.big       = (rem_ff >= dvs_ff);
   assign flags.div_busy  = (cnt_ff != {CNT_W{1'b1}});
   assign flags.q_zero    = (quo_ff == 32'd0);
   assign flags.out_busy  = rsp_valid_ff;

   // Deltas since the last update
   assign dtime  = req_time_us - last_time_ff;
   assign dsteps = req_step_total - last_step_ff;

   // One restoring divide step
   assign div_part = {rem_ff, quo_ff[31]};
   assign div_diff = div_part - {1'b0, dvs_ff};
   assign div_ge   = !div_diff[32];

   // Numerator of the speed division
   assign num_mul = 32'(stride_ff) * 32'(US_PER_S);

   // Blend weights and products
   assign w_sat   = (weight_ff > Q8_ONE) ? Q8_ONE : weight_ff;
   assign w_inv   = Q8_ONE - w_sat;
   assign mix_old = 25'(smooth_ff) * 25'(w_inv);
   assign mix_new = 25'(inst_ff) * 25'(w_sat);
   assign mix_sum = mix_old + mix_new;

   // Cap against the configured maximum
   assign capped = (mix_ff > {1'b0, max_ff}) ? max_ff : mix_ff[15:0];

   // Configuration writes
   always_comb begin
      stride_in = stride_ff;
      weight_in = weight_ff;
      max_in    = max_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STRIDE: stride_in = csr_wdata[11:0];
            CSR_WEIGHT: weight_in = csr_wdata[8:0];
            CSR_MAX:    max_in    = csr_wdata;
            default:    ;
         endcase
      end
   end

   // Datapath operations
   always_comb begin
      last_step_in  = last_step_ff;
      last_time_in  = last_time_ff;
      smooth_in     = smooth_ff;
      cur_step_in   = cur_step_ff;
      cur_time_in   = cur_time_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dvs_in        = dvs_ff;
      cnt_in        = cnt_ff;
      num_in        = num_ff;
      inst_in       = inst_ff;
      mix_in        = mix_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_speed_in  = rsp_speed_ff;
      rsp_status_in = rsp_status_ff;
      unique case (ctl.op)
         OP_NOP: ;
         OP_LOAD: begin
            // latch the item and set up interval = dtime / dsteps
            if (accept) begin
               cur_step_in = req_step_total;
               cur_time_in = req_time_us;
               rem_in      = dtime[63:32];
               quo_in      = dtime[31:0];
               dvs_in      = dsteps;
            end
         end
         OP_NUM: begin
            num_in = num_mul;
            cnt_in = '0;
         end
         OP_DIV: begin
            rem_in = div_ge ? div_diff[31:0] : div_part[31:0];
            quo_in = {quo_ff[30:0], div_ge};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_LOAD2: begin
            // set up speed = num / interval
            rem_in = '0;
            dvs_in = quo_ff;
            quo_in = num_ff;
         end
         OP_INST_Q: begin
            inst_in = (quo_ff[31:16] != 16'd0) ? SPEED_LIMIT : quo_ff[15:0];
         end
         OP_INST_ZERO: inst_in = '0;
         OP_INST_MAX:  inst_in = max_ff;
         OP_MIX:       mix_in  = mix_sum[24:8];
         OP_COMMIT: begin
            smooth_in     = capped;
            last_step_in  = cur_step_ff;
            last_time_in  = cur_time_ff;
            rsp_valid_in  = 1'b1;
            rsp_speed_in  = capped;
            rsp_status_in = 1'b0;
         end
         OP_SKIP: begin
            rsp_valid_in  = 1'b1;
            rsp_speed_in  = smooth_ff;
            rsp_status_in = 1'b1;
         end
         default: ;
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff    <= STRIDE_RESET;
         weight_ff    <= WEIGHT_RESET;
         max_ff       <= MAX_RESET;
         last_step_ff <= '0;
         last_time_ff <= '0;
         smooth_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stride_ff    <= stride_in;
         weight_ff    <= weight_in;
         max_ff       <= max_in;
         last_step_ff <= last_step_in;
         last_time_ff <= last_time_in;
         smooth_ff    <= smooth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_step_ff   <= cur_step_in;
      cur_time_ff   <= cur_time_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dvs_ff        <= dvs_in;
      cnt_ff        <= cnt_in;
      num_ff        <= num_in;
      inst_ff       <= inst_in;
      mix_ff        <= mix_in;
      rsp_speed_ff  <= rsp_speed_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ===== hw/rtl/sse_check.sv =====
// ---------------------------------------------------------------------------
// Stride speed estimator checker
// Port-level properties of the estimator, bound to the top level.
// ---------------------------------------------------------------------------
module sse_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_speed_mm_s,
   input logic        rsp_status
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_speed_mm_s) && $stable(rsp_status))
      else $error("stalled result changed");

   // Stay busy in the steps that follow an accept (S_NUM, then S_RANGE or S_WAIT_SK)
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall ##1 req_stall)
      else $error("item accepted while previous one in work");

   // A new result is written only while an item is in work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no item in work");

   // No result appears in the cycle right after an accept
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind stride_speed_estimator sse_check u_sse_check (.*);

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// Stride speed estimator testbench
// Sends step reports through the valid/stall request channel and checks each
// speed result against an in-bench estimate of the smoothed, capped speed.
// Covers idle and zero-interval items, counter and clock wrap, register
// extremes, output hold-off and random walking sequences.
// ---------------------------------------------------------------------------
module tb
   import sse_pkg::*;
();

   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 80;

   localparam logic [IDX_W-1:0] CSR_UNUSED     = 2'd3;
   localparam logic             STATUS_UPDATED = 1'b0;
   localparam logic             STATUS_NO_STEP = 1'b1;

   typedef struct {
      logic [15:0] speed;
      logic        status;
   } speed_result_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [31:0]      req_step_total;
   logic [63:0]      req_time_us;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [15:0]      rsp_speed_mm_s;
   logic             rsp_status;
   logic             csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   // Estimate state and register copies
   logic [11:0] stride_cfg;
   logic [8:0]  weight_cfg;
   logic [15:0] max_speed_cfg;
   logic [31:0] prev_steps;
   logic [63:0] prev_time_us;
   logic [15:0] est_speed;

   speed_result_type pending_speeds[$];

   bit tx_idle_on   = 1'b1;
   bit rx_idle_on   = 1'b1;
   bit hold_request = 1'b0;

   int mismatches      = 0;
   int reports_sent    = 0;
   int results_checked = 0;
   int ignored_reports = 0;
   int zero_intervals  = 0;
   int register_writes = 0;

   stride_speed_estimator uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_step_total (req_step_total),
      .req_time_us    (req_time_us),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_speed_mm_s (rsp_speed_mm_s),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Work out the result of one step report and advance the estimate
   function automatic speed_result_type advance_estimate(input logic [31:0] steps,
                                                         input logic [63:0] now);
      logic [31:0]      step_delta;
      logic [63:0]      time_delta;
      logic [63:0]      interval;
      logic [63:0]      quotient;
      logic [15:0]      instant;
      logic [8:0]       weight;
      logic [31:0]      blend;
      speed_result_type res;
      step_delta = steps - prev_steps;
      // no new step: hold state, report current speed
      if (step_delta == '0) begin
         ignored_reports++;
         res.speed  = est_speed;
         res.status = STATUS_NO_STEP;
         return res;
      end
      time_delta = now - prev_time_us;
      interval   = time_delta / {32'd0, step_delta};
      if (interval == '0) begin
         instant = max_speed_cfg;
         zero_intervals++;
      end else begin
         quotient = ({52'd0, stride_cfg} * 64'(US_PER_S)) / interval;
         instant  = (quotient > 64'(SPEED_LIMIT)) ? SPEED_LIMIT : quotient[15:0];
      end
      // blend in Q1.8, weight saturated at one
      weight = (weight_cfg > Q8_ONE) ? Q8_ONE : weight_cfg;
      blend  = (32'(est_speed) * 32'(Q8_ONE - weight) + 32'(instant) * 32'(weight)) >> 8;
      if (blend > 32'(max_speed_cfg))
         blend = 32'(max_speed_cfg);
      est_speed    = blend[15:0];
      prev_steps   = steps;
      prev_time_us = now;
      res.speed    = est_speed;
      res.status   = STATUS_UPDATED;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("ERROR at %0t: %s got %0d want %0d", $time, what, got, want);
   endtask

   // Send one step report and queue its expected result on acceptance
   task automatic send_report(input logic [31:0] steps, input logic [63:0] now);
      req_valid      <= 1'b1;
      req_step_total <= steps;
      req_time_us    <= now;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_speeds.insert(pending_speeds.size(), advance_estimate(steps, now));
      reports_sent++;
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic send_step_delta(input logic [31:0] step_delta,
                                  input logic [63:0] time_delta);
      send_report(prev_steps + step_delta, prev_time_us + time_delta);
   endtask

   // Drop valid and wait until every result is back and the block is at entry
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_speeds.size() != 0 || req_stall)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [IDX_W-1:0] index,
                                 input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_STRIDE: stride_cfg    = value[11:0];
         CSR_WEIGHT: weight_cfg    = value[8:0];
         CSR_MAX:    max_speed_cfg = value;
         default: ;
      endcase
      register_writes++;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // One random report: mostly a plausible walk, some noise
   task automatic send_walk_report();
      int unsigned kind;
      int unsigned step_delta;
      logic [63:0] pace_us;
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
         step_delta = (kind == 0) ? $urandom_range(1, 5000) : $urandom_range(1, 6);
         case ($urandom_range(0, 3))
            0: pace_us = 64'($urandom_range(0, 200));
            1: pace_us = 64'($urandom_range(100000, 1500000));
            2: pace_us = 64'($urandom_range(1, 100000));
            default: pace_us = {$urandom(), $urandom()} >> $urandom_range(0, 63);
         endcase
         send_report(prev_steps + step_delta,
                     prev_time_us + pace_us * 64'(step_delta)
                     + 64'($urandom_range(0, step_delta - 1)));
      end else if (kind < 17) begin
         send_report(prev_steps, {$urandom(), $urandom()});
      end else if (kind == 17) begin
         send_report(prev_steps + $urandom(), prev_time_us + {$urandom(), $urandom()});
      end else begin
         send_report($urandom(), {$urandom(), $urandom()});
      end
   endtask

   // Defaults after reset, ignored items, zero and huge intervals, wrap
   task automatic test_defaults_and_wrap();
      send_report(32'd0, 64'd0);
      send_step_delta(32'd1, 64'd700000);
      send_step_delta(32'd2, 64'd1);
      send_step_delta(32'd0, 64'd12345);
      send_report(prev_steps + 32'd1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_report(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_step_delta(32'd3, 64'd1500000);
      send_step_delta(32'h8000_0000, 64'h0000_0800_0000_0000);
      send_step_delta(32'd5, 64'd2500000);
      wait_until_idle();
   endtask

   // Register extremes, masking of unused bits and the unused index
   task automatic test_register_extremes();
      write_register(CSR_STRIDE, 16'h0FFF);
      write_register(CSR_WEIGHT, 16'h01FF);
      write_register(CSR_MAX, 16'hFFFF);
      send_step_delta(32'd1, 64'd1);
      send_step_delta(32'd1, 64'd62500);
      send_step_delta(32'd4, 64'd3);
      wait_until_idle();
      write_register(CSR_UNUSED, 16'(($urandom())));
      send_step_delta(32'd2, 64'd100000);
      wait_until_idle();
      write_register(CSR_STRIDE, 16'h0000);
      write_register(CSR_WEIGHT, 16'h0000);
      write_register(CSR_MAX, 16'h0000);
      send_step_delta(32'd1, 64'd1000);
      send_step_delta(32'd1, 64'd0);
      wait_until_idle();
      write_register(CSR_STRIDE, 16'h0001);
      write_register(CSR_WEIGHT, 16'h0100);
      write_register(CSR_MAX, 16'h0001);
      send_step_delta(32'd1, 64'd1);
      send_step_delta(32'd1, 64'd2000000);
      wait_until_idle();
      write_register(CSR_STRIDE, 16'hF2BC);
      write_register(CSR_WEIGHT, 16'hFE80);
      write_register(CSR_MAX, 16'd5000);
      send_step_delta(32'd2, 64'd1000000);
      wait_until_idle();
   endtask

   // Hold the output off while reports keep coming, then drain
   task automatic test_output_holdoff();
      tx_idle_on   = 1'b0;
      hold_request = 1'b1;
      repeat (10) send_walk_report();
      wait_until_idle();
      tx_idle_on = 1'b1;
   endtask

   // Random walks under random settings, idling switched per stretch
   task automatic test_random_walks();
      for (int phase = 0; phase < 7; phase++) begin
         wait_until_idle();
         case ($urandom_range(0, 4))
            0: write_register(CSR_STRIDE, {4'($urandom()), 12'd0});
            1: write_register(CSR_STRIDE, {4'($urandom()), 12'hFFF});
            default: write_register(CSR_STRIDE, {4'($urandom()),
                                                 12'($urandom_range(300, 1200))});
         endcase
         case ($urandom_range(0, 4))
            0: write_register(CSR_WEIGHT, {7'($urandom()), 9'd0});
            1: write_register(CSR_WEIGHT, {7'($urandom()), 9'd256});
            2: write_register(CSR_WEIGHT, {7'($urandom()), 9'($urandom_range(257, 511))});
            default: write_register(CSR_WEIGHT, {7'($urandom()),
                                                 9'($urandom_range(1, 255))});
         endcase
         case ($urandom_range(0, 5))
            0: write_register(CSR_MAX, 16'd0);
            1: write_register(CSR_MAX, 16'hFFFF);
            default: write_register(CSR_MAX, 16'($urandom_range(500, 20000)));
         endcase
         for (int i = 0; i < 160; i++) begin
            if (i % 40 == 0) begin
               tx_idle_on = ($urandom_range(0, 3) != 0);
               rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_walk_report();
         end
      end
      wait_until_idle();
   endtask

   // Back-to-back reports with both sides always ready
   task automatic test_full_rate();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      repeat (100) send_walk_report();
      wait_until_idle();
   endtask

   // Result side: random stalls and the long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall    <= 1'b0;
            hold_request = 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_speeds
      speed_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_speeds.size() == 0) begin
            report_mismatch("result with nothing pending, speed",
                            32'(rsp_speed_mm_s), 32'd0);
         end else begin
            want = pending_speeds.pop_front();
            results_checked++;
            if (rsp_speed_mm_s !== want.speed)
               report_mismatch("speed_mm_s", 32'(rsp_speed_mm_s), 32'(want.speed));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
         end
      end
   end

   // End the run when nothing moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_step_total <= '0;
      req_time_us    <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_STRIDE;
      csr_wdata      <= '0;
      stride_cfg     = STRIDE_RESET;
      weight_cfg     = WEIGHT_RESET;
      max_speed_cfg  = MAX_RESET;
      prev_steps     = '0;
      prev_time_us   = '0;
      est_speed      = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_defaults_and_wrap();
      test_register_extremes();
      test_output_holdoff();
      test_random_walks();
      test_full_rate();

      repeat (DRAIN_CYCLES) @(posedge clock);
      while (pending_speeds.size() != 0) begin
         void'(pending_speeds.pop_front());
         report_mismatch("result never arrived, pending count", 32'd1, 32'd0);
      end
      $display("Covered %0d step reports: %0d without a new step, %0d at zero interval.",
               reports_sent, ignored_reports, zero_intervals);
      $display("Checked %0d results over %0d register writes and a %0d-cycle hold-off.",
               results_checked, register_writes, HOLD_CYCLES);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
